@@ rtl/framed_sample_stream_deframer_macros.svh @@
// Assertion helpers used by the deframer engine module.
`ifndef FRAMED_SAMPLE_STREAM_DEFRAMER_MACROS_SVH
`define FRAMED_SAMPLE_STREAM_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FSSD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FSSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/fssd_pkg.sv @@
package fssd_pkg;

	localparam int SYNC_BYTES_MAX = 8;
	localparam int CH_MAX = 32;
	localparam int REM_STEPS = 16;

	localparam int CFG_IDX_W = 4;
	localparam int CFG_COUNT = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_LEN   = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_MODE  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 4'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_SIZE = 4'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 4'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_FORMAT     = 4'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_CKS_EN     = 4'd7;

	localparam logic [1:0] SIZE_FIXED = 2'd0;
	localparam logic [1:0] SIZE_ONE   = 2'd1;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_CKS  = 2'd1;
	localparam logic [1:0] STATUS_ZERO = 2'd2;
	localparam logic [1:0] STATUS_MULT = 2'd3;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [63:0] sample_value;
		logic [4:0]  channel;
		logic [15:0] set_index;
		logic        frame_last;
		logic [1:0]  frame_status;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} in_head_t;

	typedef struct packed {
		logic        start;
		logic [15:0] dividend;
		logic [8:0]  divisor;
	} rem_req_t;

	typedef struct packed {
		logic done;
		logic is_zero;
	} rem_rsp_t;

	// log2 of the sample size in bytes
	function automatic logic [1:0] sample_shift(input logic [2:0] fmt);
		logic [1:0] s;
		case (fmt)
			3'd0, 3'd1: s = 2'd0;
			3'd2, 3'd3: s = 2'd1;
			3'd4, 3'd5, 3'd6: s = 2'd2;
			default: s = 2'd3;
		endcase
		return s;
	endfunction

endpackage

@@ rtl/fssd_in_fifo.sv @@
module fssd_in_fifo
	import fssd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] rx_byte,
	output logic       full,
	output in_head_t   head,
	input  logic       take
);

	logic [7:0] mem_q [4];
	logic [1:0] wptr_q;
	logic [1:0] rptr_q;
	logic [2:0] cnt_q;
	logic       wr;
	logic       rd;

	assign full = (cnt_q == 3'd4);
	assign wr = push && !full;
	assign rd = take && head.valid;
	assign head.valid = (cnt_q != 3'd0);
	assign head.data = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) wptr_q <= wptr_q + 2'd1;
			if (rd) rptr_q <= rptr_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr} - {2'd0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= rx_byte;
	end

endmodule

@@ rtl/fssd_rem.sv @@
module fssd_rem
	import fssd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  rem_req_t req,
	output rem_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [3:0]  cnt_q;
	logic [8:0]  rem_q;
	logic [15:0] dvd_q;
	logic [8:0]  dvs_q;
	logic [9:0]  trial;
	logic [8:0]  rem_d;

	assign trial = {rem_q, dvd_q[15]};
	assign rem_d = (trial >= {1'b0, dvs_q}) ? 9'(trial - {1'b0, dvs_q}) : trial[8:0];
	assign rsp.done = done_q;
	assign rsp.is_zero = (rem_q == 9'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(REM_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			dvd_q <= {dvd_q[14:0], 1'b0};
		end
	end

endmodule

@@ rtl/fssd_engine.sv @@
`include "framed_sample_stream_deframer_macros.svh"

module fssd_engine
	import fssd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  in_head_t             head,
	output logic                 take,
	input  logic                 out_full,
	output logic                 res_push,
	output result_t              res,
	output rem_req_t             rem_req,
	input  rem_rsp_t             rem_rsp
);

	localparam logic [1:0] ST_FSTART = 2'd0;
	localparam logic [1:0] ST_FCHK   = 2'd1;
	localparam logic [1:0] ST_RUN    = 2'd2;
	localparam logic [1:0] ST_SCHK   = 2'd3;

	logic [63:0] cfg_sync_word_q;
	logic [3:0]  cfg_sync_len_q;
	logic [1:0]  cfg_size_mode_q;
	logic        cfg_be_q;
	logic [15:0] cfg_fixed_q;
	logic [5:0]  cfg_ch_q;
	logic [2:0]  cfg_fmt_q;
	logic        cfg_cks_q;

	logic [1:0]  state_q, state_d;
	logic        fixed_ok_q, fixed_ok_d;

	logic [2:0]  sync_pos_q, sync_pos_d;
	logic        sync_found_q, sync_found_d;
	logic        size_found_q, size_found_d;
	logic [7:0]  first_q, first_d;
	logic        seen_q, seen_d;
	logic [15:0] psize_q, psize_d;
	logic [15:0] pcount_q, pcount_d;
	logic [63:0] asm_q, asm_d;
	logic [2:0]  bpos_q, bpos_d;
	logic [4:0]  chan_q, chan_d;
	logic [15:0] set_q, set_d;
	logic [7:0]  csum_q, csum_d;

	logic        cfg_wr;
	logic [5:0]  eff_ch;
	logic [1:0]  shift;
	logic [3:0]  sbytes;
	logic [8:0]  set_bytes;
	logic [3:0]  sync_len;
	logic [7:0]  want;
	logic        settings_ok;
	logic        sz_ready;
	logic [15:0] sz;
	logic [63:0] asm_next;
	logic [3:0]  bpos_next;
	logic        clr;

	assign cfg_wr = cfg_we && (cfg_index < CFG_IDX_W'(CFG_COUNT));
	assign eff_ch = (cfg_ch_q == 6'd0) ? 6'd1 :
		(cfg_ch_q > 6'(CH_MAX)) ? 6'(CH_MAX) : cfg_ch_q;
	assign shift = sample_shift(cfg_fmt_q);
	assign sbytes = 4'd1 << shift;
	assign set_bytes = 9'(eff_ch) << shift;
	assign sync_len = (cfg_sync_len_q > 4'(SYNC_BYTES_MAX)) ? 4'(SYNC_BYTES_MAX) : cfg_sync_len_q;
	assign want = cfg_sync_word_q[{sync_pos_q, 3'b000} +: 8];
	assign settings_ok = (cfg_sync_len_q != 4'd0) &&
		((cfg_size_mode_q != SIZE_FIXED) || ((cfg_fixed_q != 16'd0) && fixed_ok_q));
	assign asm_next = cfg_be_q ? {asm_q[55:0], head.data} :
		(asm_q | (64'(head.data) << {bpos_q, 3'b000}));
	assign bpos_next = {1'b0, bpos_q} + 4'd1;

	always_comb begin
		state_d      = state_q;
		fixed_ok_d   = fixed_ok_q;
		sync_pos_d   = sync_pos_q;
		sync_found_d = sync_found_q;
		size_found_d = size_found_q;
		first_d      = first_q;
		seen_d       = seen_q;
		psize_d      = psize_q;
		pcount_d     = pcount_q;
		asm_d        = asm_q;
		bpos_d       = bpos_q;
		chan_d       = chan_q;
		set_d        = set_q;
		csum_d       = csum_q;
		take         = 1'b0;
		res_push     = 1'b0;
		res          = '0;
		rem_req      = '0;
		sz_ready     = 1'b0;
		sz           = '0;
		clr          = 1'b0;
		case (state_q)
			ST_FSTART: begin
				rem_req.start    = 1'b1;
				rem_req.dividend = cfg_fixed_q;
				rem_req.divisor  = set_bytes;
				state_d          = ST_FCHK;
			end
			ST_FCHK: begin
				if (rem_rsp.done) begin
					fixed_ok_d = rem_rsp.is_zero;
					state_d    = ST_RUN;
				end
			end
			ST_SCHK: begin
				if (rem_rsp.done) begin
					state_d = ST_RUN;
					if (rem_rsp.is_zero) begin
						size_found_d = 1'b1;
					end else begin
						res_push         = 1'b1;
						res.kind         = KIND_STATUS;
						res.frame_last   = 1'b1;
						res.frame_status = STATUS_MULT;
						clr              = 1'b1;
					end
				end
			end
			ST_RUN: begin
				if (head.valid && !out_full) begin
					take = 1'b1;
					if (settings_ok) begin
						if (!sync_found_q) begin
							if (head.data == want) begin
								if ({1'b0, sync_pos_q} + 4'd1 >= sync_len) begin
									sync_found_d = 1'b1;
									if (cfg_size_mode_q == SIZE_FIXED) begin
										size_found_d = 1'b1;
										psize_d      = cfg_fixed_q;
									end
								end else begin
									sync_pos_d = sync_pos_q + 3'd1;
								end
							end
						end else if (!size_found_q) begin
							if (cfg_size_mode_q == SIZE_ONE) begin
								sz_ready = 1'b1;
								sz       = {8'd0, head.data};
							end else if (!seen_q) begin
								first_d = head.data;
								seen_d  = 1'b1;
							end else begin
								sz_ready = 1'b1;
								sz       = cfg_be_q ? {first_q, head.data} : {head.data, first_q};
								seen_d   = 1'b0;
							end
							if (sz_ready) begin
								if (sz == 16'd0) begin
									res_push         = 1'b1;
									res.kind         = KIND_STATUS;
									res.frame_last   = 1'b1;
									res.frame_status = STATUS_ZERO;
									clr              = 1'b1;
								end else begin
									psize_d          = sz;
									rem_req.start    = 1'b1;
									rem_req.dividend = sz;
									rem_req.divisor  = set_bytes;
									state_d          = ST_SCHK;
								end
							end
						end else if (pcount_q >= psize_q) begin
							res_push         = 1'b1;
							res.kind         = KIND_STATUS;
							res.frame_last   = 1'b1;
							res.frame_status = (csum_q == head.data) ? STATUS_OK : STATUS_CKS;
							clr              = 1'b1;
						end else begin
							csum_d   = csum_q + head.data;
							pcount_d = pcount_q + 16'd1;
							if (bpos_next == sbytes) begin
								res_push         = 1'b1;
								res.kind         = KIND_SAMPLE;
								res.sample_value = asm_next;
								res.channel      = chan_q;
								res.set_index    = set_q;
								res.frame_status = STATUS_OK;
								asm_d            = '0;
								bpos_d           = '0;
								if ({1'b0, chan_q} + 6'd1 >= eff_ch) begin
									chan_d = '0;
									set_d  = set_q + 16'd1;
								end else begin
									chan_d = chan_q + 5'd1;
								end
								if (pcount_d >= psize_q && !cfg_cks_q) begin
									res.frame_last = 1'b1;
									clr            = 1'b1;
								end
							end else begin
								asm_d  = asm_next;
								bpos_d = bpos_next[2:0];
							end
						end
					end
				end
			end
			default: state_d = ST_FSTART;
		endcase
		if (clr) begin
			sync_pos_d   = '0;
			sync_found_d = 1'b0;
			size_found_d = 1'b0;
			first_d      = '0;
			seen_d       = 1'b0;
			psize_d      = '0;
			pcount_d     = '0;
			asm_d        = '0;
			bpos_d       = '0;
			chan_d       = '0;
			set_d        = '0;
			csum_d       = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_sync_word_q <= 64'hAA;
			cfg_sync_len_q  <= 4'd1;
			cfg_size_mode_q <= SIZE_FIXED;
			cfg_be_q        <= 1'b0;
			cfg_fixed_q     <= 16'd1;
			cfg_ch_q        <= 6'd1;
			cfg_fmt_q       <= 3'd0;
			cfg_cks_q       <= 1'b0;
			state_q         <= ST_FSTART;
			fixed_ok_q      <= 1'b0;
			sync_pos_q      <= '0;
			sync_found_q    <= 1'b0;
			size_found_q    <= 1'b0;
			first_q         <= '0;
			seen_q          <= 1'b0;
			psize_q         <= '0;
			pcount_q        <= '0;
			asm_q           <= '0;
			bpos_q          <= '0;
			chan_q          <= '0;
			set_q           <= '0;
			csum_q          <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_SYNC_WORD:  cfg_sync_word_q <= cfg_data;
				CFG_SYNC_LEN:   cfg_sync_len_q  <= cfg_data[3:0];
				CFG_SIZE_MODE:  cfg_size_mode_q <= cfg_data[1:0];
				CFG_BIG_ENDIAN: cfg_be_q        <= cfg_data[0];
				CFG_FIXED_SIZE: cfg_fixed_q     <= cfg_data[15:0];
				CFG_CHANNELS:   cfg_ch_q        <= cfg_data[5:0];
				CFG_FORMAT:     cfg_fmt_q       <= cfg_data[2:0];
				CFG_CKS_EN:     cfg_cks_q       <= cfg_data[0];
				default: ;
			endcase
			state_q      <= ST_FSTART;
			sync_pos_q   <= '0;
			sync_found_q <= 1'b0;
			size_found_q <= 1'b0;
			first_q      <= '0;
			seen_q       <= 1'b0;
			psize_q      <= '0;
			pcount_q     <= '0;
			asm_q        <= '0;
			bpos_q       <= '0;
			chan_q       <= '0;
			set_q        <= '0;
			csum_q       <= '0;
		end else begin
			state_q      <= state_d;
			fixed_ok_q   <= fixed_ok_d;
			sync_pos_q   <= sync_pos_d;
			sync_found_q <= sync_found_d;
			size_found_q <= size_found_d;
			first_q      <= first_d;
			seen_q       <= seen_d;
			psize_q      <= psize_d;
			pcount_q     <= pcount_d;
			asm_q        <= asm_d;
			bpos_q       <= bpos_d;
			chan_q       <= chan_d;
			set_q        <= set_d;
			csum_q       <= csum_d;
		end
	end

	`FSSD_ASSERT_NOW(a_push_room, res_push, !out_full, "result pushed into a full queue")
	`FSSD_ASSERT_NOW(a_take_run, take, state_q == ST_RUN, "item taken outside run state")
	`FSSD_ASSERT_NOW(a_size_chk, state_q == ST_SCHK, sync_found_q && !size_found_q,
		"size check outside size field")
	`FSSD_ASSERT_NEXT(a_chan_range, 1'b1, {1'b0, chan_q} < eff_ch, "channel beyond count")

endmodule

@@ rtl/fssd_out_fifo.sv @@
module fssd_out_fifo
	import fssd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    res_push,
	input  result_t res,
	output logic    out_full,
	output logic    empty,
	input  logic    pop,
	output result_t head
);

	result_t    mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       wr;
	logic       rd;

	assign out_full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign wr = res_push && !out_full;
	assign rd = pop && !empty;
	assign head = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (wr) wptr_q <= !wptr_q;
			if (rd) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= res;
	end

endmodule

@@ rtl/framed_sample_stream_deframer.sv @@
// Sync-word frame deframer with an additive checksum.
// Input channel: rx_byte with push/full, one received byte per item; an item is taken
// at a clock edge with push high and full low. A four-item input queue feeds the framer.
// Result channel: empty/pop; the oldest result sits on kind, sample_value, channel,
// set_index, frame_last and frame_status while empty is low, and leaves on pop.
// Configuration: cfg_we, cfg_index, cfg_data; write only while the block is idle.
// Each accepted write clears the framing state.
// A pushed byte is registered in the input queue and its result in the output queue.
// Throughput: one byte per cycle for sync, checksum and payload bytes while the output
// queue has room. The byte that completes a size field starts the shared 16-step
// remainder unit, which checks the size against channels times sample size; bytes queue
// meanwhile. After reset and after each configuration write the same unit checks the
// fixed payload size; bytes pushed then wait in the input queue.
// Reset restores the register defaults and empties both queues.
// When the receiver stalls, up to two results wait in the output queue, then the
// framer holds and the input queue fills, and full rises.
module framed_sample_stream_deframer
	import fssd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           rx_byte,
	output logic                 empty,
	input  logic                 pop,
	output logic                 kind,
	output logic [63:0]          sample_value,
	output logic [4:0]           channel,
	output logic [15:0]          set_index,
	output logic                 frame_last,
	output logic [1:0]           frame_status,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);

	in_head_t in_head;
	logic     take;
	logic     out_full;
	logic     res_push;
	result_t  res;
	result_t  out_head;
	rem_req_t rem_req;
	rem_rsp_t rem_rsp;

	fssd_in_fifo u_in_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.rx_byte (rx_byte),
		.full    (full),
		.head    (in_head),
		.take    (take)
	);

	fssd_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rem_req),
		.rsp    (rem_rsp)
	);

	fssd_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.head      (in_head),
		.take      (take),
		.out_full  (out_full),
		.res_push  (res_push),
		.res       (res),
		.rem_req   (rem_req),
		.rem_rsp   (rem_rsp)
	);

	fssd_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res      (res),
		.out_full (out_full),
		.empty    (empty),
		.pop      (pop),
		.head     (out_head)
	);

	assign kind         = out_head.kind;
	assign sample_value = out_head.sample_value;
	assign channel      = out_head.channel;
	assign set_index    = out_head.set_index;
	assign frame_last   = out_head.frame_last;
	assign frame_status = out_head.frame_status;

endmodule
